/* sv/poar_pkg.sv */
`timescale 1ns / 1ps

package poar_pkg;

  // Fixed width of an entry id on the ports.
  localparam int unsigned ENTRY_W = 4;

  // Function codes of an input word.
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_RET = 1'b1;

  typedef struct packed {
    logic               func;
    logic [ENTRY_W-1:0] entry_id;
  } in_word_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] granted_id;
    logic               granted;
    logic               evicted;
    logic               overflow;
  } out_word_t;

  // Commands broadcast to every active-list cell. At most one is set.
  typedef struct packed {
    logic compact;  // close holes left by a removal, one place per cycle
    logic rotate;   // head moves to the tail, rest shift toward the head
    logic append;   // first free cell takes the new id
    logic remove;   // cells holding the given id go empty
  } list_ctrl_t;

  // Commands broadcast to every free-stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

endpackage

/* sv/poar_list_cell.sv */
`timescale 1ns / 1ps

// One place of the ordered active list. Cell 0 is the oldest entry.
module poar_list_cell
  import poar_pkg::*;
#(
  parameter int unsigned ID_W = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  list_ctrl_t      ctrl,
  input  logic            prev_valid,  // tied high on the head cell
  input  logic            next_valid,  // tied low on the tail cell
  input  logic [ID_W-1:0] next_id,
  input  logic [ID_W-1:0] head_id,
  input  logic [ID_W-1:0] new_id,
  input  logic [ID_W-1:0] del_id,
  output logic            valid,
  output logic [ID_W-1:0] id
);

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    if (ctrl.compact) begin
      if (!valid_r && next_valid) begin
        valid_nxt = 1'b1;
        id_nxt    = next_id;
      end else if (valid_r && !prev_valid) begin
        valid_nxt = 1'b0;
      end
    end else if (ctrl.rotate) begin
      if (valid_r) begin
        id_nxt = next_valid ? next_id : head_id;
      end
    end else if (ctrl.append) begin
      if (!valid_r && prev_valid) begin
        valid_nxt = 1'b1;
        id_nxt    = new_id;
      end
    end else if (ctrl.remove) begin
      if (valid_r && (id_r == del_id)) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;

endmodule

/* sv/poar_stack_cell.sv */
`timescale 1ns / 1ps

// One place of the free stack. Cell 0 is the top.
module poar_stack_cell
  import poar_pkg::*;
#(
  parameter int unsigned ID_W     = 4,
  parameter int unsigned RESET_ID = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  stack_ctrl_t     ctrl,
  input  logic [ID_W-1:0] prev_id,  // pushed id on the top cell
  input  logic [ID_W-1:0] next_id,
  output logic [ID_W-1:0] id
);

  logic [ID_W-1:0] id_r, id_nxt;

  always_comb begin
    id_nxt = id_r;
    if (ctrl.push) begin
      id_nxt = prev_id;
    end else if (ctrl.pop) begin
      id_nxt = next_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= ID_W'(RESET_ID);
    end else begin
      id_r <= id_nxt;
    end
  end

  assign id = id_r;

endmodule

/* sv/pool_allocator_oldest_reclaim.sv */
`timescale 1ns / 1ps

// Pool allocator with reclaim of the oldest entry. A get word pops the top
// of the free stack and appends the id to the active list; with the stack
// empty it reclaims the oldest active id (evicted = 1) and moves it to the
// tail. A return word removes every copy of the id from the active list and
// pushes it on the free stack (overflow = 1 if the stack is full). Each word
// gives exactly one result word. A get needs no compaction, nor does a return
// that leaves no hole ahead of a live entry. A return that opens holes inside
// the active list holds in_stall while the cell chain closes them. Each
// cycle a live entry with a hole just ahead of it moves up one place; an
// entry directly behind a moving one does not move yet. So a hole travels one
// place per cycle toward the tail. Result words sit in a two-word output
// queue, so input is taken while one result still waits. After reset the
// stack holds ids 0 to POOL_SIZE-1 with the largest on top; no clearing
// pass is needed.
module pool_allocator_oldest_reclaim
  import poar_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_word_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // Internal ids are wide enough for every pool id, never narrower than
  // the port field.
  localparam int unsigned IdW  = (POOL_SIZE > 16) ? $clog2(POOL_SIZE) : ENTRY_W;
  localparam int unsigned CntW = $clog2(POOL_SIZE + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(POOL_SIZE);
  localparam logic [IdW:0]    IdLimit = (IdW + 1)'(POOL_SIZE);
  localparam logic [1:0]      OqFull  = 2'd2;

  // ---------------------------------------------------------------------
  // Cell chains
  // ---------------------------------------------------------------------
  logic [POOL_SIZE-1:0] lst_vld;
  logic [IdW-1:0]       lst_id [POOL_SIZE];
  logic [IdW-1:0]       stk_id [POOL_SIZE];
  logic [POOL_SIZE-1:0] gap_vec;

  list_ctrl_t  lst_ctrl;
  stack_ctrl_t stk_ctrl;
  logic [IdW-1:0] del_id;
  logic [IdW-1:0] push_id;

  genvar k;
  generate
    for (k = 0; k < POOL_SIZE; k++) begin : g_cell
      logic           prev_v;
      logic           next_v;
      logic [IdW-1:0] next_lid;
      logic [IdW-1:0] prev_sid;
      logic [IdW-1:0] next_sid;

      if (k == 0) begin : g_head
        assign prev_v   = 1'b1;
        assign prev_sid = push_id;
      end else begin : g_mid
        assign prev_v   = lst_vld[k-1];
        assign prev_sid = stk_id[k-1];
      end

      if (k == POOL_SIZE - 1) begin : g_tail
        assign next_v     = 1'b0;
        assign next_lid   = '0;
        assign next_sid   = stk_id[k];
        assign gap_vec[k] = 1'b0;
      end else begin : g_body
        assign next_v     = lst_vld[k+1];
        assign next_lid   = lst_id[k+1];
        assign next_sid   = stk_id[k+1];
        // hole followed by a live entry: compaction still running
        assign gap_vec[k] = !lst_vld[k] && lst_vld[k+1];
      end

      poar_list_cell #(
        .ID_W (IdW)
      ) u_list (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lst_ctrl),
        .prev_valid (prev_v),
        .next_valid (next_v),
        .next_id    (next_lid),
        .head_id    (lst_id[0]),
        .new_id     (stk_id[0]),
        .del_id     (del_id),
        .valid      (lst_vld[k]),
        .id         (lst_id[k])
      );

      // top of stack is cell 0 and resets to the largest id
      poar_stack_cell #(
        .ID_W     (IdW),
        .RESET_ID (POOL_SIZE - 1 - k)
      ) u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (stk_ctrl),
        .prev_id (prev_sid),
        .next_id (next_sid),
        .id      (stk_id[k])
      );
    end
  endgenerate

  logic gap;
  assign gap = |gap_vec;

  // ---------------------------------------------------------------------
  // Word decode
  // ---------------------------------------------------------------------
  logic [CntW-1:0] free_cnt_r, free_cnt_nxt;
  logic [1:0]      oq_cnt_r, oq_cnt_nxt;
  logic            in_acc;
  logic            is_get;
  logic            id_ok;
  logic            free_nz;
  logic            free_full;
  out_word_t       res;

  assign in_stall  = gap || (oq_cnt_r == OqFull);
  assign in_acc    = in_valid && !in_stall;
  assign is_get    = (in_data.func == FUNC_GET);
  assign del_id    = IdW'(in_data.entry_id);
  assign push_id   = del_id;
  assign id_ok     = ({1'b0, del_id} < IdLimit);
  assign free_nz   = (free_cnt_r != '0);
  assign free_full = (free_cnt_r == CntFull);

  always_comb begin
    lst_ctrl     = '0;
    stk_ctrl     = '0;
    res          = '0;
    free_cnt_nxt = free_cnt_r;
    if (gap) begin
      lst_ctrl.compact = 1'b1;
    end else if (in_acc) begin
      if (is_get) begin
        if (free_nz) begin
          // pop a free id; the list cells take it as the new tail
          stk_ctrl.pop    = 1'b1;
          lst_ctrl.append = 1'b1;
          free_cnt_nxt    = free_cnt_r - 1'b1;
          res.granted_id  = stk_id[0][ENTRY_W-1:0];
          res.granted     = 1'b1;
        end else if (lst_vld[0]) begin
          // reclaim the oldest active id
          lst_ctrl.rotate = 1'b1;
          res.granted_id  = lst_id[0][ENTRY_W-1:0];
          res.granted     = 1'b1;
          res.evicted     = 1'b1;
        end
      end else if (id_ok) begin
        lst_ctrl.remove = 1'b1;
        if (!free_full) begin
          stk_ctrl.push = 1'b1;
          free_cnt_nxt  = free_cnt_r + 1'b1;
        end else begin
          res.overflow = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= CntFull;
    end else begin
      free_cnt_r <= free_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Two-word output queue; oq_head_r drives the port
  // ---------------------------------------------------------------------
  out_word_t oq_head_r, oq_head_nxt;
  out_word_t oq_tail_r, oq_tail_nxt;
  logic      oq_pop;

  assign oq_pop = (oq_cnt_r != 2'd0) && !out_stall;

  always_comb begin
    oq_head_nxt = oq_head_r;
    oq_tail_nxt = oq_tail_r;
    oq_cnt_nxt  = oq_cnt_r + {1'b0, in_acc} - {1'b0, oq_pop};
    if (oq_cnt_r == OqFull) begin
      if (oq_pop) begin
        oq_head_nxt = oq_tail_r;
      end
    end else if (oq_cnt_r == 2'd1) begin
      if (in_acc) begin
        if (oq_pop) begin
          oq_head_nxt = res;
        end else begin
          oq_tail_nxt = res;
        end
      end
    end else begin
      if (in_acc) begin
        oq_head_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_cnt_r <= 2'd0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oq_head_r <= oq_head_nxt;
    oq_tail_r <= oq_tail_nxt;
  end

  assign out_valid = (oq_cnt_r != 2'd0);
  assign out_data  = oq_head_r;

endmodule
